// ===== hw/rtl/tgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tgr_pkg
// shared types and constants of the topic gibbs resampler
// ----------------------------------------------------------------------------
package tgr_pkg;

   // default sizes
   localparam int NUM_TOPICS_DEF = 16;
   localparam int VOCAB_SIZE_DEF = 4096;
   localparam int MAX_TOKENS_DEF = 1024;
   localparam int PHI_BITS_DEF   = 16;

   // fixed field widths
   localparam int TYPE_W        = 3;
   localparam int WORD_W        = 12;
   localparam int TOPIC_W       = 4;
   localparam int POS_W         = 10;
   localparam int PHI_IN_W      = 16;
   localparam int DRAW_W        = 16;
   localparam int OUT_CNT_W     = 11;
   localparam int TOPICS_USED_W = 5;
   localparam int ALPHA_W       = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int REQ_DATA_W    = 64;
   localparam int RSP_DATA_W    = 32;

   localparam logic [TOPICS_USED_W-1:0] TOPICS_USED_RST = 5'd16;
   localparam logic [ALPHA_W-1:0]       ALPHA_RST       = 16'd256;

   typedef enum logic [TYPE_W-1:0] {
      REQ_WRITE_PHI = 3'd0,
      REQ_BEGIN_DOC = 3'd1,
      REQ_ADD_TOKEN = 3'd2,
      REQ_RESAMPLE  = 3'd3,
      REQ_READ_CNT  = 3'd4
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOPICS_USED = 1'b0,
      CSR_ALPHA       = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK,
      ST_OLD,
      ST_SUM,
      ST_MUL1,
      ST_MUL2,
      ST_SRCH,
      ST_FIX,
      ST_FIX2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic phi_wr;
      logic tok_wr;
      logic cnt_wr;
      logic cnt_clr;
   } mem_ctl_type;

   typedef struct packed {
      logic sum_clr;
      logic srch_clr;
      logic dv;
      logic srch;
      logic tgt1;
      logic tgt2;
   } walk_ctl_type;

   typedef struct packed {
      logic busy;
      logic found;
      logic sum_zero;
   } walk_sts_type;

endpackage

// ===== hw/rtl/topic_gibbs_resampler.sv =====
// ----------------------------------------------------------------------------
// topic_gibbs_resampler
// collapsed gibbs topic resampling for one document over a fixed phi table
// ----------------------------------------------------------------------------
// usage
//   req_* stream carries one request per beat: table write, begin document,
//   add token, resample token or read count; every beat gives one rsp beat
//   rsp_* stream returns topic, count, document total and an error flag
//   csr_* writes topics_used (index 0) and alpha (index 1); user must write only while idle, unenforced
// sequencing
//   one request at a time; table write, begin, add and read pass the lookup
//   and done states into the rsp register; a resample with K topics in use
//   makes a sum pass and, unless the sum is zero, a search pass over the
//   shared phi and count memory ports, one topic read per cycle, plus the two-step target product
// reset
//   counts and total read zero, topics_used = 16, alpha = 1.0; the phi table
//   and the token topics hold nothing until written
// stall
//   the result waits in the rsp register; the next request is taken while it
//   waits, and its own result holds until the register frees
// ----------------------------------------------------------------------------
module topic_gibbs_resampler import tgr_pkg::*; #(
   parameter int NUM_TOPICS = NUM_TOPICS_DEF,
   parameter int VOCAB_SIZE = VOCAB_SIZE_DEF,
   parameter int MAX_TOKENS = MAX_TOKENS_DEF,
   parameter int PHI_BITS   = PHI_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata from bit 0: req_type, word_id, topic_in, token_pos,
   // phi_value, uniform_draw, zero fill
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata from bit 0: new_topic, count_out, total_out, error, zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int TIX_W     = $clog2(NUM_TOPICS);
   localparam int CW        = $clog2(MAX_TOKENS + 1);
   localparam int PW        = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
   localparam int PHI_DEPTH = VOCAB_SIZE * NUM_TOPICS;
   localparam int AW        = $clog2(PHI_DEPTH);
   localparam int RW        = CW + 9;
   localparam int WW        = PHI_BITS + RW;
   localparam int SW        = WW + TOPICS_USED_W;

   // request fields
   logic [TYPE_W-1:0]   req_type;
   logic [WORD_W-1:0]   req_word;
   logic [TOPIC_W-1:0]  req_topic;
   logic [POS_W-1:0]    req_pos;
   logic [PHI_IN_W-1:0] req_phi;
   logic [DRAW_W-1:0]   req_draw;

   assign req_type  = req_tdata[2:0];
   assign req_word  = req_tdata[14:3];
   assign req_topic = req_tdata[18:15];
   assign req_pos   = req_tdata[28:19];
   assign req_phi   = req_tdata[44:29];
   assign req_draw  = req_tdata[60:45];

   state_type state_ff, state_in;

   // latched request
   logic [TYPE_W-1:0]   kind_ff;
   logic [WORD_W-1:0]   word_ff;
   logic [TOPIC_W-1:0]  topic_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [PHI_IN_W-1:0] phi_ff;
   logic [DRAW_W-1:0]   draw_ff;

   logic [TIX_W-1:0] old_ff, old_in;
   logic [TIX_W-1:0] chosen_ff, chosen_in;
   logic [TOPICS_USED_W-1:0] iss_ff, iss_in;
   logic             dv_ff;
   logic [TIX_W-1:0] dk_ff;
   logic [CW-1:0]    tot_ff, tot_in;

   logic [TOPICS_USED_W-1:0] topics_used_ff;
   logic [ALPHA_W-1:0]       alpha_ff;

   // pending result
   logic [TOPIC_W-1:0]   res_topic_ff, res_topic_in;
   logic [OUT_CNT_W-1:0] res_count_ff, res_count_in;
   logic                 res_err_ff, res_err_in;
   logic                 fin;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_load;

   // memory and walk wiring
   mem_ctl_type         mc;
   walk_ctl_type        wc;
   walk_sts_type        ws;
   logic [AW-1:0]       phi_addr;
   logic [PHI_BITS-1:0] phi_rdata;
   logic [PW-1:0]       tok_addr;
   logic [TIX_W-1:0]    tok_wdata;
   logic [TIX_W-1:0]    tok_rdata;
   logic [TIX_W-1:0]    cnt_addr;
   logic [CW-1:0]       cnt_wdata;
   logic [CW-1:0]       cnt_rdata;
   logic [TIX_W-1:0]    walk_chosen;

   // derived conditions
   logic [TOPICS_USED_W-1:0] k_used;
   logic [TIX_W-1:0]         last_topic;
   logic walking, issuing, drained;
   logic word_ok, topic_tab_ok, topic_use_ok, pos_ok, room_ok, old_ok;
   logic req_acc;

   assign req_acc    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign k_used     = (32'(topics_used_ff) < NUM_TOPICS) ? topics_used_ff
                                                           : TOPICS_USED_W'(NUM_TOPICS);
   assign last_topic = TIX_W'(k_used - 1'b1);
   assign walking    = (state_ff == ST_SUM) || (state_ff == ST_SRCH);
   assign issuing    = walking && (iss_ff < k_used);
   assign drained    = !issuing && !dv_ff && !ws.busy;

   assign word_ok      = 32'(word_ff) < VOCAB_SIZE;
   assign topic_tab_ok = 32'(topic_ff) < NUM_TOPICS;
   assign topic_use_ok = 32'(topic_ff) < 32'(k_used);
   assign pos_ok       = 32'(pos_ff) < MAX_TOKENS;
   assign room_ok      = 32'(tot_ff) < MAX_TOKENS;
   // stored topic must be in use and still counted
   assign old_ok       = (32'(old_ff) < 32'(k_used)) && (cnt_rdata != '0);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         topics_used_ff <= TOPICS_USED_RST;
         alpha_ff       <= ALPHA_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TOPICS_USED: topics_used_ff <= csr_wdata[TOPICS_USED_W-1:0];
            CSR_ALPHA:       alpha_ff       <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            if ((kind_ff == REQ_RESAMPLE) && word_ok && pos_ok) begin
               state_in = ST_OLD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_OLD: begin
            state_in = old_ok ? ST_SUM : ST_DONE;
         end
         ST_SUM: begin
            if (drained) state_in = ST_MUL1;
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: begin
            state_in = ws.sum_zero ? ST_FIX : ST_SRCH;
         end
         ST_SRCH: begin
            if (drained) state_in = ST_FIX;
         end
         ST_FIX:  state_in = ST_FIX2;
         ST_FIX2: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and register next values
   always_comb begin
      mc           = '0;
      wc           = '0;
      fin          = 1'b0;
      res_topic_in = topic_ff;
      res_count_in = '0;
      res_err_in   = 1'b1;
      old_in       = old_ff;
      chosen_in    = chosen_ff;
      iss_in       = iss_ff;
      tot_in       = tot_ff;
      tok_addr     = PW'(pos_ff);
      tok_wdata    = TIX_W'(topic_ff);
      cnt_addr     = TIX_W'(topic_ff);
      cnt_wdata    = cnt_rdata + 1'b1;
      phi_addr     = AW'(32'(word_ff) * NUM_TOPICS
                         + (walking ? 32'(iss_ff) : 32'(topic_ff)));

      wc.dv   = dv_ff;
      wc.srch = (state_ff == ST_SRCH);

      case (state_ff)
         ST_IDLE: begin
            // look up count at the request topic and the token slot
            tok_addr = PW'(req_pos);
            cnt_addr = TIX_W'(req_topic);
         end
         ST_LOOK: begin
            case (req_kind_type'(kind_ff))
               REQ_WRITE_PHI: begin
                  fin = 1'b1;
                  if (word_ok && topic_tab_ok) begin
                     mc.phi_wr    = 1'b1;
                     res_count_in = OUT_CNT_W'(cnt_rdata);
                     res_err_in   = 1'b0;
                  end
               end
               REQ_BEGIN_DOC: begin
                  fin        = 1'b1;
                  mc.cnt_clr = 1'b1;
                  tot_in     = '0;
                  res_err_in = 1'b0;
               end
               REQ_ADD_TOKEN: begin
                  fin = 1'b1;
                  if (topic_use_ok && pos_ok && room_ok) begin
                     mc.tok_wr    = 1'b1;
                     mc.cnt_wr    = 1'b1;
                     tot_in       = tot_ff + 1'b1;
                     res_count_in = OUT_CNT_W'(cnt_rdata + 1'b1);
                     res_err_in   = 1'b0;
                  end
               end
               REQ_RESAMPLE: begin
                  // fetch the count of the token's stored topic
                  cnt_addr = tok_rdata;
                  old_in   = tok_rdata;
                  fin      = !(word_ok && pos_ok);
               end
               REQ_READ_CNT: begin
                  fin = 1'b1;
                  if (topic_use_ok) begin
                     res_count_in = OUT_CNT_W'(cnt_rdata);
                     res_err_in   = 1'b0;
                  end
               end
               default: fin = 1'b1;
            endcase
         end
         ST_OLD: begin
            // take the token out of its topic
            cnt_addr   = old_ff;
            cnt_wdata  = cnt_rdata - 1'b1;
            mc.cnt_wr  = old_ok;
            wc.sum_clr = 1'b1;
            iss_in     = '0;
            fin        = !old_ok;
         end
         ST_SUM, ST_SRCH: begin
            cnt_addr = TIX_W'(iss_ff);
            if (issuing) iss_in = iss_ff + 1'b1;
            if ((state_ff == ST_SRCH) && drained) begin
               chosen_in = ws.found ? walk_chosen : last_topic;
            end
         end
         ST_MUL1: begin
            wc.tgt1 = 1'b1;
         end
         ST_MUL2: begin
            wc.tgt2     = 1'b1;
            wc.srch_clr = 1'b1;
            iss_in      = '0;
            // no weight anywhere: last topic in use
            chosen_in   = last_topic;
         end
         ST_FIX: begin
            cnt_addr = chosen_ff;
         end
         ST_FIX2: begin
            cnt_addr     = chosen_ff;
            tok_wdata    = chosen_ff;
            mc.cnt_wr    = 1'b1;
            mc.tok_wr    = 1'b1;
            fin          = 1'b1;
            res_topic_in = TOPIC_W'(chosen_ff);
            res_count_in = OUT_CNT_W'(cnt_rdata + 1'b1);
            res_err_in   = 1'b0;
         end
         default: ;
      endcase
   end

   // output register
   assign rsp_load     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
         tot_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= issuing;
         tot_ff       <= tot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff  <= req_type;
         word_ff  <= req_word;
         topic_ff <= req_topic;
         pos_ff   <= req_pos;
         phi_ff   <= req_phi;
         draw_ff  <= req_draw;
      end
      old_ff    <= old_in;
      chosen_ff <= chosen_in;
      iss_ff    <= iss_in;
      dk_ff     <= TIX_W'(iss_ff);
      if (fin) begin
         res_topic_ff <= res_topic_in;
         res_count_ff <= res_count_in;
         res_err_ff   <= res_err_in;
      end
      if (rsp_load) begin
         rsp_data_ff <= {5'd0, res_err_ff, OUT_CNT_W'(tot_ff), res_count_ff, res_topic_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   tgr_mem #(
      .PHI_BITS   (PHI_BITS),
      .PHI_DEPTH  (PHI_DEPTH),
      .AW         (AW),
      .MAX_TOKENS (MAX_TOKENS),
      .PW         (PW),
      .NUM_TOPICS (NUM_TOPICS),
      .TIX_W      (TIX_W),
      .CW         (CW)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mc),
      .phi_addr  (phi_addr),
      .phi_wdata (PHI_BITS'(phi_ff)),
      .phi_rdata (phi_rdata),
      .tok_addr  (tok_addr),
      .tok_wdata (tok_wdata),
      .tok_rdata (tok_rdata),
      .cnt_addr  (cnt_addr),
      .cnt_wdata (cnt_wdata),
      .cnt_rdata (cnt_rdata)
   );

   tgr_walk #(
      .PHI_BITS (PHI_BITS),
      .CW       (CW),
      .TIX_W    (TIX_W),
      .RW       (RW),
      .WW       (WW),
      .SW       (SW)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .ctl       (wc),
      .phi_rdata (phi_rdata),
      .cnt_rdata (cnt_rdata),
      .tag       (dk_ff),
      .alpha     (alpha_ff),
      .draw      (draw_ff),
      .sts       (ws),
      .chosen    (walk_chosen)
   );

endmodule

// ===== hw/rtl/tgr_mem.sv =====
// ----------------------------------------------------------------------------
// tgr_mem
// word-topic table, token topic store and per-topic document counts
// ----------------------------------------------------------------------------
module tgr_mem import tgr_pkg::*; #(
   parameter int PHI_BITS   = PHI_BITS_DEF,
   parameter int PHI_DEPTH  = VOCAB_SIZE_DEF * NUM_TOPICS_DEF,
   parameter int AW         = 16,
   parameter int MAX_TOKENS = MAX_TOKENS_DEF,
   parameter int PW         = 10,
   parameter int NUM_TOPICS = NUM_TOPICS_DEF,
   parameter int TIX_W      = 4,
   parameter int CW         = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  mem_ctl_type         ctl,
   input  logic [AW-1:0]       phi_addr,
   input  logic [PHI_BITS-1:0] phi_wdata,
   output logic [PHI_BITS-1:0] phi_rdata,
   input  logic [PW-1:0]       tok_addr,
   input  logic [TIX_W-1:0]    tok_wdata,
   output logic [TIX_W-1:0]    tok_rdata,
   input  logic [TIX_W-1:0]    cnt_addr,
   input  logic [CW-1:0]       cnt_wdata,
   output logic [CW-1:0]       cnt_rdata
);

   logic [PHI_BITS-1:0] phi_mem [PHI_DEPTH];
   logic [TIX_W-1:0]    tok_mem [MAX_TOKENS];
   logic [CW-1:0]       cnt_mem [NUM_TOPICS];
   logic [NUM_TOPICS-1:0] cv_ff;
   logic                cnt_rv_ff;
   logic [PHI_BITS-1:0] phi_rd_ff;
   logic [TIX_W-1:0]    tok_rd_ff;
   logic [CW-1:0]       cnt_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.phi_wr) begin
         phi_mem[phi_addr] <= phi_wdata;
      end
      phi_rd_ff <= phi_mem[phi_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.tok_wr) begin
         tok_mem[tok_addr] <= tok_wdata;
      end
      tok_rd_ff <= tok_mem[tok_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.cnt_wr) begin
         cnt_mem[cnt_addr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_addr];
   end

   // valid bits: an entry not written since the document began reads zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff     <= '0;
         cnt_rv_ff <= 1'b0;
      end else begin
         cnt_rv_ff <= cv_ff[cnt_addr];
         if (ctl.cnt_clr) begin
            cv_ff <= '0;
         end else if (ctl.cnt_wr) begin
            cv_ff[cnt_addr] <= 1'b1;
         end
      end
   end

   assign phi_rdata = phi_rd_ff;
   assign tok_rdata = tok_rd_ff;
   assign cnt_rdata = cnt_rv_ff ? cnt_rd_ff : '0;

endmodule

// ===== hw/rtl/tgr_walk.sv =====
// ----------------------------------------------------------------------------
// tgr_walk
// weight multiplier, weight sum, scaled target and cumulative search
// ----------------------------------------------------------------------------
module tgr_walk import tgr_pkg::*; #(
   parameter int PHI_BITS = PHI_BITS_DEF,
   parameter int CW       = 11,
   parameter int TIX_W    = 4,
   parameter int RW       = CW + 9,
   parameter int WW       = PHI_BITS + RW,
   parameter int SW       = WW + TOPICS_USED_W
) (
   input  logic                clock,
   input  logic                reset,
   input  walk_ctl_type        ctl,
   input  logic [PHI_BITS-1:0] phi_rdata,
   input  logic [CW-1:0]       cnt_rdata,
   input  logic [TIX_W-1:0]    tag,
   input  logic [ALPHA_W-1:0]  alpha,
   input  logic [DRAW_W-1:0]   draw,
   output walk_sts_type        sts,
   output logic [TIX_W-1:0]    chosen
);

   logic [RW-1:0]    right;
   logic [WW-1:0]    w_ff;
   logic             wv_ff;
   logic [TIX_W-1:0] wk_ff;
   logic [SW-1:0]    sum_ff;
   logic [SW-1:0]    cum_ff;
   logic [SW-1:0]    cum_in;
   logic [SW-1:0]    target_ff;
   logic             found_ff;
   logic [TIX_W-1:0] chosen_ff;
   logic [63:0]      s64;
   logic [47:0]      p0_ff;
   logic [47:0]      p1_ff;
   logic [79:0]      prod;

   // (count << 8) + alpha in q8.8
   assign right  = (RW'(cnt_rdata) << 8) + RW'(alpha);
   assign cum_in = cum_ff + SW'(w_ff);
   assign s64    = 64'(sum_ff);
   assign prod   = {p1_ff, 32'd0} + 80'(p0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         wv_ff <= ctl.dv;
         if (ctl.srch_clr) begin
            found_ff <= 1'b0;
         end else if (ctl.srch && wv_ff && !found_ff && (target_ff < cum_in)) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= WW'(PHI_BITS'(phi_rdata) * right);
      wk_ff <= tag;
      if (ctl.sum_clr) begin
         sum_ff <= '0;
      end else if (wv_ff && !ctl.srch) begin
         sum_ff <= sum_ff + SW'(w_ff);
      end
      if (ctl.srch_clr) begin
         cum_ff <= '0;
      end else if (wv_ff && ctl.srch) begin
         cum_ff <= cum_in;
      end
      if (ctl.srch && wv_ff && !found_ff && (target_ff < cum_in)) begin
         chosen_ff <= wk_ff;
      end
      // floor(sum * draw / 2^16), split into two 32 by 16 products
      if (ctl.tgt1) begin
         p0_ff <= 48'(s64[31:0] * draw);
         p1_ff <= 48'(s64[63:32] * draw);
      end
      if (ctl.tgt2) begin
         target_ff <= SW'(prod >> 16);
      end
   end

   assign sts.busy     = wv_ff;
   assign sts.found    = found_ff;
   assign sts.sum_zero = (sum_ff == '0);
   assign chosen       = chosen_ff;

endmodule

// ===== hw/rtl/tgr_checker.sv =====
// ----------------------------------------------------------------------------
// tgr_checker
// port-level checks of the topic gibbs resampler
// ----------------------------------------------------------------------------
module tgr_checker import tgr_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed under stall");

   // waiting request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("req beat changed while waiting");

   // one request at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // refused requests report a zero count
   a_err_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26] |-> rsp_tdata[14:4] == '0)
      else $error("error beat with nonzero count");

   // padding bits stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:27] == '0)
      else $error("rsp padding not zero");

endmodule

bind topic_gibbs_resampler tgr_checker u_tgr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
